/* sv/sss_pkg.sv */
`timescale 1ns / 1ps
package sss_pkg;

  localparam int DEF_DIGIT_COUNT  = 4;
  localparam int DEF_SEGMENT_BITS = 8;
  localparam int DEF_DWELL_WIDTH  = 16;

  localparam int NUMBER_BITS   = 14;
  localparam int CFG_BITS      = 16;
  localparam int POS_BITS      = 3;
  localparam int BIT_IDX_BITS  = 3;
  localparam int SEG_CODE_BITS = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CFG_BITS-1:0] DWELL_RESET = 16'd5000;

  typedef enum logic [2:0] {
    PH_SELECT = 3'd0,
    PH_CLEAR  = 3'd1,
    PH_DATA   = 3'd2,
    PH_RISE   = 3'd3,
    PH_FALL   = 3'd4,
    PH_LATCH  = 3'd5,
    PH_DWELL  = 3'd6
  } phase_t;

  typedef struct packed {
    phase_t                  kind;
    logic [POS_BITS-1:0]     digit;
    logic [BIT_IDX_BITS-1:0] bit_idx;
    logic                    start;
    logic [NUMBER_BITS-1:0]  value;
  } cmd_t;

  function automatic logic [31:0] pow10(input int n);
    logic [31:0] r;
    r = 32'd1;
    for (int i = 0; i < n; i++) begin
      r = r * 32'd10;
    end
    return r;
  endfunction

  function automatic logic [SEG_CODE_BITS-1:0] seg_code(input logic [3:0] d);
    logic [SEG_CODE_BITS-1:0] c;
    unique case (d)
      4'd0:    c = 8'h03;
      4'd1:    c = 8'h9F;
      4'd2:    c = 8'h25;
      4'd3:    c = 8'h0D;
      4'd4:    c = 8'h99;
      4'd5:    c = 8'h49;
      4'd6:    c = 8'h41;
      4'd7:    c = 8'h1F;
      4'd8:    c = 8'h01;
      4'd9:    c = 8'h09;
      default: c = 8'hFF;
    endcase
    return c;
  endfunction

endpackage

/* sv/sss_front.sv */
`timescale 1ns / 1ps
module sss_front import sss_pkg::*; #(
  parameter int DIGIT_COUNT  = DEF_DIGIT_COUNT,
  parameter int SEGMENT_BITS = DEF_SEGMENT_BITS,
  parameter int DWELL_WIDTH  = DEF_DWELL_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick,
  input  logic [NUMBER_BITS-1:0] number_value,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_BITS-1:0]    cfg_data,
  output cmd_t                   cmd
);

  localparam int PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int BW = $clog2(SEGMENT_BITS + 1);

  phase_t                 phase, phase_next;
  logic [PW-1:0]          digit_position, digit_position_next;
  logic [BW-1:0]          bit_position, bit_position_next;
  logic [DWELL_WIDTH-1:0] dwell_count, dwell_count_next;
  logic [CFG_BITS-1:0]    dwell_ticks;
  logic [BW-1:0]          bit_inc;

  assign cfg_ready = 1'b1;
  assign bit_inc   = bit_position + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_ticks <= DWELL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dwell_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SELECT;
      digit_position <= '0;
      bit_position   <= '0;
      dwell_count    <= '0;
    end else if (tick) begin
      phase          <= phase_next;
      digit_position <= digit_position_next;
      bit_position   <= bit_position_next;
      dwell_count    <= dwell_count_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    digit_position_next = digit_position;
    bit_position_next   = bit_position;
    dwell_count_next    = dwell_count;
    unique case (phase)
      PH_SELECT: phase_next = PH_CLEAR;
      PH_CLEAR: begin
        bit_position_next = '0;
        phase_next        = PH_DATA;
      end
      PH_DATA: phase_next = PH_RISE;
      PH_RISE: phase_next = PH_FALL;
      PH_FALL: begin
        bit_position_next = bit_inc;
        phase_next = (bit_inc >= BW'(SEGMENT_BITS)) ? PH_LATCH : PH_DATA;
      end
      PH_LATCH: begin
        dwell_count_next = DWELL_WIDTH'(dwell_ticks);
        phase_next       = PH_DWELL;
      end
      PH_DWELL: begin
        if (dwell_count <= DWELL_WIDTH'(1)) begin
          dwell_count_next = '0;
          if (digit_position == PW'(DIGIT_COUNT - 1)) begin
            digit_position_next = '0;
          end else begin
            digit_position_next = digit_position + 1'b1;
          end
          phase_next = PH_SELECT;
        end else begin
          dwell_count_next = dwell_count - 1'b1;
        end
      end
      default: phase_next = PH_CLEAR;
    endcase
  end

  always_comb begin
    cmd.kind    = phase;
    cmd.digit   = POS_BITS'(digit_position);
    cmd.bit_idx = BIT_IDX_BITS'(bit_position);
    cmd.start   = (phase == PH_SELECT) && (digit_position == '0);
    cmd.value   = number_value;
  end

  a_data_bit_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> bit_position < BW'(SEGMENT_BITS))
    else $error("Data phase reached with the bit position past the segment code.");

endmodule

/* sv/sss_queue.sv */
`timescale 1ns / 1ps
module sss_queue import sss_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  output logic avail,
  output cmd_t head,
  input  logic pop
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entry [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign avail = (count != '0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("Queue count did not grow on a lone transfer in.");

endmodule

/* sv/sss_digits.sv */
`timescale 1ns / 1ps
module sss_digits import sss_pkg::*; #(
  parameter int DIGIT_COUNT = DEF_DIGIT_COUNT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NUMBER_BITS-1:0] value,
  input  logic [POS_BITS-1:0]    rd_pos,
  output logic [3:0]             rd_digit,
  output logic                   busy
);

  localparam int PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [31:0] LIMIT = pow10(DIGIT_COUNT) - 32'd1;

  logic [3:0]             held [DIGIT_COUNT];
  logic [31:0]            weight [DIGIT_COUNT];
  logic [NUMBER_BITS-1:0] rem;
  logic [NUMBER_BITS-1:0] sat_value;
  logic [PW-1:0]          conv_pos;
  logic [31:0]            w;
  logic [3:0]             step_digit;
  logic [31:0]            step_sub;

  for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_weight
    assign weight[k] = pow10(DIGIT_COUNT - 1 - k);
  end

  assign sat_value = (32'(value) > LIMIT) ? NUMBER_BITS'(LIMIT) : value;
  assign rd_digit  = held[rd_pos[PW-1:0]];

  always_comb begin
    w          = weight[conv_pos];
    step_digit = '0;
    step_sub   = '0;
    for (int d = 1; d <= 9; d++) begin
      if (32'(rem) >= 32'(d) * w) begin
        step_digit = 4'(d);
        step_sub   = 32'(d) * w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      conv_pos <= '0;
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        held[k] <= '0;
      end
    end else if (start) begin
      busy     <= 1'b1;
      conv_pos <= '0;
    end else if (busy) begin
      held[conv_pos] <= step_digit;
      if (conv_pos == PW'(DIGIT_COUNT - 1)) begin
        busy <= 1'b0;
      end else begin
        conv_pos <= conv_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= sat_value;
    end else if (busy) begin
      rem <= rem - NUMBER_BITS'(step_sub);
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("A new number was captured while the digit split was still running.");

endmodule

/* sv/sss_back.sv */
`timescale 1ns / 1ps
module sss_back import sss_pkg::*; #(
  parameter int DIGIT_COUNT = DEF_DIGIT_COUNT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       avail,
  input  cmd_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       serial_data,
  output logic       shift_clock,
  output logic       latch_clock,
  output logic       digit_line_a,
  output logic       digit_line_b,
  output logic [1:0] digit_index,
  output logic       scan_start
);

  logic                     capture;
  logic [3:0]               cur_digit;
  logic [SEG_CODE_BITS-1:0] code;
  logic                     conv_busy;

  assign pop     = avail && (!out_valid || !out_stall);
  assign capture = pop && (head.kind == PH_SELECT) && head.start;
  assign code    = seg_code(cur_digit);

  sss_digits #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_digits (
    .clk      (clk),
    .rst      (rst),
    .start    (capture),
    .value    (head.value),
    .rd_pos   (head.digit),
    .rd_digit (cur_digit),
    .busy     (conv_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      serial_data  <= 1'b0;
      shift_clock  <= 1'b0;
      latch_clock  <= 1'b0;
      digit_line_a <= 1'b0;
      digit_line_b <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        unique case (head.kind)
          PH_SELECT: begin
            digit_line_a <= ~head.digit[0];
            digit_line_b <= ~head.digit[1];
          end
          PH_CLEAR: begin
            shift_clock <= 1'b0;
            latch_clock <= 1'b0;
          end
          PH_DATA:  serial_data <= code[head.bit_idx];
          PH_RISE:  shift_clock <= 1'b1;
          PH_FALL:  shift_clock <= 1'b0;
          PH_LATCH: latch_clock <= 1'b1;
          PH_DWELL: ;
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      digit_index <= head.digit[1:0];
      scan_start  <= head.start;
    end
  end

  a_start_on_first_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid && scan_start |-> digit_index == 2'd0)
    else $error("Scan start reported on a digit other than the first.");

  a_capture_idle_split: assert property (@(posedge clk) disable iff (rst)
    pop && head.kind == PH_DATA |-> !(conv_busy && head.digit == '0 && $past(capture)))
    else $error("First digit read before the split produced it.");

endmodule

/* sv/seven_segment_scan_serializer.sv */
`timescale 1ns / 1ps
// Drives a four-digit multiplexed display through a serial segment shift register.
// Each input transfer is one tick of the pin waveform; on the first tick of a scan
// the number_value of that transfer is captured, held to 9999 at most and split
// into decimal digits. Every tick gives exactly one output transfer with the pin
// levels after that tick: serial_data, shift_clock, latch_clock, the two digit
// select lines, the digit being driven and a scan_start flag.
// The dwell time per digit comes from a write on the cfg channel (cfg_data), taken
// whenever cfg_valid is high; write it only while no ticks are in flight.
// An accepted tick is written into the two-entry command queue between the tick
// sequencer and the pin stage, then registered in the pin stage outputs; one tick
// per cycle is sustained while out_stall is low. in_stall only rises once a stall
// has lasted long enough to fill the queue; a stalled result holds its value.
// The digit split works through the digits one after another after capture and runs
// ahead of the pin stage, which first needs a digit two ticks after the capture.
// After reset the dwell is 5000 ticks, the scan starts at the first digit and
// serial_data, shift_clock, latch_clock and both digit select lines are low.
module seven_segment_scan_serializer import sss_pkg::*; #(
  parameter int DIGIT_COUNT  = DEF_DIGIT_COUNT,
  parameter int SEGMENT_BITS = DEF_SEGMENT_BITS,
  parameter int DWELL_WIDTH  = DEF_DWELL_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [NUMBER_BITS-1:0] number_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   serial_data,
  output logic                   shift_clock,
  output logic                   latch_clock,
  output logic                   digit_line_a,
  output logic                   digit_line_b,
  output logic [1:0]             digit_index,
  output logic                   scan_start,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_BITS-1:0]    cfg_data
);

  logic tick;
  logic q_full;
  logic q_avail;
  logic q_pop;
  cmd_t cmd;
  cmd_t q_head;

  assign in_stall = q_full;
  assign tick     = in_valid && !in_stall;

  sss_front #(
    .DIGIT_COUNT  (DIGIT_COUNT),
    .SEGMENT_BITS (SEGMENT_BITS),
    .DWELL_WIDTH  (DWELL_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick),
    .number_value (number_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (cmd)
  );

  sss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (tick),
    .push_data (cmd),
    .full      (q_full),
    .avail     (q_avail),
    .head      (q_head),
    .pop       (q_pop)
  );

  sss_back #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .avail        (q_avail),
    .head         (q_head),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .serial_data  (serial_data),
    .shift_clock  (shift_clock),
    .latch_clock  (latch_clock),
    .digit_line_a (digit_line_a),
    .digit_line_b (digit_line_b),
    .digit_index  (digit_index),
    .scan_start   (scan_start)
  );

endmodule

/* sim/seven_segment_scan_serializer_tb.sv */
`timescale 1ns / 1ps

module seven_segment_scan_serializer_tb import sss_pkg::*;;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;

  localparam logic [9:0][7:0] GLYPHS = {
    8'h09, 8'h01, 8'h1F, 8'h41, 8'h49, 8'h99, 8'h0D, 8'h25, 8'h9F, 8'h03
  };

  localparam int OPENER_COUNT = 7;
  localparam logic [OPENER_COUNT-1:0][NUMBER_BITS-1:0] OPENERS = {
    14'd9090, 14'd5678, 14'd1234, 14'd10000, 14'd9999, 14'd16383, 14'd0
  };

  typedef struct packed {
    logic       data;
    logic       shift;
    logic       latch;
    logic       line_a;
    logic       line_b;
    logic [1:0] index;
    logic       start;
  } pins_t;

  class pin_predictor;
    logic [3:0]  digits [4];
    logic [1:0]  position;
    phase_t      step;
    logic [3:0]  bit_count;
    logic [15:0] dwell_left;
    logic [15:0] dwell_setting;
    pins_t       levels;
    pins_t       expected_pins [$];
    int          errors;

    function new();
      for (int k = 0; k < 4; k++) begin
        digits[k] = 4'd0;
      end
      position = 2'd0;
      step = PH_SELECT;
      bit_count = 4'd0;
      dwell_left = 16'd0;
      dwell_setting = DWELL_RESET;
      levels = '0;
      errors = 0;
    endfunction

    function void set_dwell(logic [15:0] ticks);
      dwell_setting = ticks;
    endfunction

    function bit at_scan_start();
      return step == PH_SELECT && position == 2'd0;
    endfunction

    function int pending();
      return expected_pins.size();
    endfunction

    function string show(pins_t p);
      return $sformatf("data=%0b shift=%0b latch=%0b a=%0b b=%0b digit=%0d start=%0b",
                       p.data, p.shift, p.latch, p.line_a, p.line_b, p.index, p.start);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void take_tick(logic [NUMBER_BITS-1:0] number);
      int held;
      levels.start = 1'b0;
      levels.index = position;
      case (step)
        PH_CLEAR: begin
          levels.shift = 1'b0;
          levels.latch = 1'b0;
          bit_count = 4'd0;
          step = PH_DATA;
        end
        PH_DATA: begin
          levels.data = GLYPHS[digits[position]][bit_count[2:0]];
          step = PH_RISE;
        end
        PH_RISE: begin
          levels.shift = 1'b1;
          step = PH_FALL;
        end
        PH_FALL: begin
          levels.shift = 1'b0;
          bit_count = bit_count + 4'd1;
          step = (bit_count >= 4'(DEF_SEGMENT_BITS)) ? PH_LATCH : PH_DATA;
        end
        PH_LATCH: begin
          levels.latch = 1'b1;
          dwell_left = dwell_setting;
          step = PH_DWELL;
        end
        PH_DWELL: begin
          if (dwell_left <= 16'd1) begin
            dwell_left = 16'd0;
            position = position + 2'd1;
            step = PH_SELECT;
          end else begin
            dwell_left = dwell_left - 16'd1;
          end
        end
        default: begin
          if (position == 2'd0) begin
            held = int'(number);
            if (held > 9999) begin
              held = 9999;
            end
            digits[0] = 4'(held / 1000);
            digits[1] = 4'((held / 100) % 10);
            digits[2] = 4'((held / 10) % 10);
            digits[3] = 4'(held % 10);
            levels.start = 1'b1;
          end
          levels.line_a = ~position[0];
          levels.line_b = ~position[1];
          step = PH_CLEAR;
        end
      endcase
      expected_pins.push_back(levels);
    endfunction

    function void compare_pins(pins_t got);
      pins_t want;
      if (expected_pins.size() == 0) begin
        flag({"Output transfer with nothing expected: ", show(got)});
        return;
      end
      want = expected_pins.pop_front();
      if (got !== want) begin
        flag({"Pin mismatch: expected ", show(want), ", got ", show(got)});
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [NUMBER_BITS-1:0] number_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   serial_data;
  logic                   shift_clock;
  logic                   latch_clock;
  logic                   digit_line_a;
  logic                   digit_line_b;
  logic [1:0]             digit_index;
  logic                   scan_start;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_BITS-1:0]    cfg_data = '0;

  pin_predictor predictor;
  int ticks_sent = 0;
  int results_seen = 0;
  int openers_used = 0;
  int idle_cycles = 0;
  bit hold_done = 1'b0;

  seven_segment_scan_serializer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .number_value (number_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .serial_data  (serial_data),
    .shift_clock  (shift_clock),
    .latch_clock  (latch_clock),
    .digit_line_a (digit_line_a),
    .digit_line_b (digit_line_b),
    .digit_index  (digit_index),
    .scan_start   (scan_start),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The number only matters on a scan start tick, so the interesting values go there.
  function automatic logic [NUMBER_BITS-1:0] next_number();
    logic [NUMBER_BITS-1:0] v;
    v = NUMBER_BITS'($urandom_range(0, 16383));
    if (predictor.at_scan_start()) begin
      if (openers_used < OPENER_COUNT) begin
        v = OPENERS[openers_used];
        openers_used++;
      end else begin
        case ($urandom_range(0, 3))
          0: v = NUMBER_BITS'($urandom_range(0, 16383));
          1: v = NUMBER_BITS'($urandom_range(0, 9999));
          2: v = NUMBER_BITS'($urandom_range(9990, 10010));
          default: v = OPENERS[$urandom_range(0, 3)];
        endcase
      end
    end
    return v;
  endfunction

  task automatic run_ticks(input int count);
    int sent;
    bit calm;
    sent = 0;
    while (sent < count) begin
      calm = ticks_sent >= 540 && ticks_sent < 840;
      if (!calm && $urandom_range(0, 99) < 32) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end else begin
        number_value <= next_number();
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        predictor.take_tick(number_value);
        sent++;
        ticks_sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic write_dwell(input logic [CFG_BITS-1:0] ticks);
    while (predictor.pending() != 0) @(posedge clk);
    cfg_data <= ticks;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    predictor.set_dwell(ticks);
  endtask

  initial begin
    predictor = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    run_ticks(20);
    write_dwell(16'd1);
    run_ticks(340);
    write_dwell(16'd0);
    run_ticks(230);
    write_dwell(16'd2);
    run_ticks(240);
    write_dwell(CFG_BITS'($urandom_range(3, 12)));
    run_ticks(300);
    write_dwell(16'd1);
    run_ticks(250);
    write_dwell(16'hFFFF);
    run_ticks(80);
    while (predictor.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (predictor.errors == 0) begin
      $display("seven_segment_scan_serializer test passed");
    end else begin
      $display("seven_segment_scan_serializer test failed");
    end
    $finish;
  end

  // The long hold lets the internal queue fill so that in_stall must rise.
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!hold_done && results_seen >= 560) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (results_seen >= 950 && results_seen < 1200) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 32);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      predictor.compare_pins({serial_data, shift_clock, latch_clock, digit_line_a,
                              digit_line_b, digit_index, scan_start});
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("seven_segment_scan_serializer test failed");
      $finish;
    end
  end

endmodule

/* files.f */
sv/sss_pkg.sv
sv/sss_front.sv
sv/sss_queue.sv
sv/sss_digits.sv
sv/sss_back.sv
sv/seven_segment_scan_serializer.sv
sim/seven_segment_scan_serializer_tb.sv
